>>> hw/rtl/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// types, constants and the code-to-character map of the base32 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b32e_pkg;

    localparam int BYTE_W          = 8;
    localparam int CODE_W          = 5;
    localparam int CHAR_W          = 7;
    localparam int GROUP_W         = 40;
    localparam int HELD_W          = 3;
    localparam int CHARS_PER_RUN   = 8;
    localparam int CHAR_IDX_W      = 3;
    localparam int DCHARS_W        = 4;

    localparam logic [HELD_W-1:0]     BYTES_PER_GROUP = 3'd5;
    localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX   = 3'd7;
    localparam logic [CHAR_W-1:0]     PAD_CHAR        = 7'd61;
    localparam logic [CHAR_W-1:0]     ALPHA_BASE      = 7'd65;
    localparam logic [CHAR_W-1:0]     DIGIT_BASE      = 7'd50;
    localparam logic [CODE_W-1:0]     ALPHA_COUNT     = 5'd26;

    // one group handed from the front to the back
    typedef struct packed {
        logic [GROUP_W-1:0]  bits;        // zero-filled group, first byte on top
        logic [DCHARS_W-1:0] data_chars;  // characters before padding
        logic                last;        // group ends the message
    } group_t;

    // 5-bit code to ascii: A-Z then 2-7
    function automatic logic [CHAR_W-1:0] code_to_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        if (code < ALPHA_COUNT)
            ch = ALPHA_BASE + {2'b00, code};
        else
            ch = DIGIT_BASE + {2'b00, code - ALPHA_COUNT};
        return ch;
    endfunction

    // ceil(8n/5) for n bytes in a group
    function automatic logic [DCHARS_W-1:0] data_chars_of(input logic [HELD_W-1:0] n);
        logic [DCHARS_W-1:0] d;
        case (n)
            3'd1:    d = 4'd2;
            3'd2:    d = 4'd4;
            3'd3:    d = 4'd5;
            3'd4:    d = 4'd7;
            default: d = 4'd8;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b32e_front.sv
// ----------------------------------------------------------------------------
// b32e_front
// gathers bytes into groups of five and hands finished groups to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [b32e_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        final_byte,
    output logic                             grp_push,
    output b32e_pkg::group_t                 grp_data,
    input  wire logic                        grp_full
);
    import b32e_pkg::*;

    logic [31:0]       group_bits_reg, group_bits_next;
    logic [HELD_W-1:0] bytes_held_reg, bytes_held_next;
    logic [HELD_W-1:0] n;
    logic              accept;
    logic              group_done;

    assign full       = grp_full;
    assign accept     = push && !grp_full;
    assign n          = (bytes_held_reg > 3'd4) ? BYTES_PER_GROUP : bytes_held_reg + 3'd1;
    assign group_done = (n == BYTES_PER_GROUP) || final_byte;
    assign grp_push   = accept && group_done;

    always_comb
    begin
        grp_data.data_chars = data_chars_of(n);
        grp_data.last       = final_byte;
        // zero-fill so the first byte sits at the top
        case (n)
            3'd1:    grp_data.bits = {data_byte, 32'd0};
            3'd2:    grp_data.bits = {group_bits_reg[7:0], data_byte, 24'd0};
            3'd3:    grp_data.bits = {group_bits_reg[15:0], data_byte, 16'd0};
            3'd4:    grp_data.bits = {group_bits_reg[23:0], data_byte, 8'd0};
            default: grp_data.bits = {group_bits_reg, data_byte};
        endcase
    end

    always_comb
    begin
        group_bits_next = group_bits_reg;
        bytes_held_next = bytes_held_reg;
        if (accept)
        begin
            if (group_done)
            begin
                group_bits_next = '0;
                bytes_held_next = '0;
            end
            else
            begin
                group_bits_next = {group_bits_reg[23:0], data_byte};
                bytes_held_next = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg <= '0;
            bytes_held_reg <= '0;
        end
        else
        begin
            group_bits_reg <= group_bits_next;
            bytes_held_reg <= bytes_held_next;
        end
    end

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_held_reg <= 3'd4)
        else $error("byte count out of range");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> bytes_held_reg == 3'd0)
        else $error("group not cleared after last byte");

    a_fifth_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes_held_reg == 3'd4 |-> grp_push)
        else $error("full group not handed on");

endmodule

`default_nettype wire

>>> hw/rtl/b32e_queue.sv
// ----------------------------------------------------------------------------
// b32e_queue
// short queue of finished groups between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire b32e_pkg::group_t wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output b32e_pkg::group_t      rd_data,
    output logic                  nonempty
);
    import b32e_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    group_t            slots_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign nonempty = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count overflow");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        full && !rd_en |=> full)
        else $error("queue drained without a read");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/b32e_back.sv
// ----------------------------------------------------------------------------
// b32e_back
// turns one group into eight characters, one per cycle while pop keeps up, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        grp_valid,
    input  wire b32e_pkg::group_t            grp_data,
    output logic                             grp_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [b32e_pkg::CHAR_W-1:0]      text_char,
    output logic                             run_end,
    output logic                             message_end
);
    import b32e_pkg::*;

    logic                  busy_reg, busy_next;
    logic [GROUP_W-1:0]    shift_reg, shift_next;
    logic [CHAR_IDX_W-1:0] idx_reg, idx_next;
    logic [DCHARS_W-1:0]   dchars_reg, dchars_next;
    logic                  last_reg, last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  run_end_reg, run_end_next;
    logic                  msg_end_reg, msg_end_next;
    logic                  emit;
    logic                  final_char;
    logic [CHAR_W-1:0]     cur_char;

    assign emit       = busy_reg && (!out_valid_reg || pop);
    assign final_char = (idx_reg == LAST_CHAR_IDX);
    assign grp_pop    = grp_valid && (!busy_reg || (emit && final_char));
    assign cur_char   = ({1'b0, idx_reg} < dchars_reg)
                      ? code_to_char(shift_reg[GROUP_W-1 -: CODE_W]) : PAD_CHAR;

    assign empty       = !out_valid_reg;
    assign text_char   = char_reg;
    assign run_end     = run_end_reg;
    assign message_end = msg_end_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        shift_next     = shift_reg;
        idx_next       = idx_reg;
        dchars_next    = dchars_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        run_end_next   = run_end_reg;
        msg_end_next   = msg_end_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = cur_char;
            run_end_next   = final_char;
            msg_end_next   = final_char && last_reg;
            shift_next     = shift_reg << CODE_W;
            idx_next       = idx_reg + 1'b1;
            if (final_char)
                busy_next = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (grp_pop)
        begin
            busy_next   = 1'b1;
            shift_next  = grp_data.bits;
            idx_next    = '0;
            dchars_next = grp_data.data_chars;
            last_next   = grp_data.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        dchars_reg  <= dchars_next;
        last_reg    <= last_next;
        char_reg    <= char_next;
        run_end_reg <= run_end_next;
        msg_end_reg <= msg_end_next;
    end

    a_msg_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && msg_end_reg |-> run_end_reg)
        else $error("message end off a run end");

    a_eighth_marks: assert property (@(posedge clk) disable iff (!rst_n)
        emit && final_char |=> out_valid_reg && run_end_reg)
        else $error("eighth character not marked");

    a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && grp_valid |=> busy_reg && idx_reg == '0)
        else $error("waiting group not taken");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop && busy_reg |-> emit && final_char)
        else $error("group taken mid run");

endmodule

`default_nettype wire

>>> hw/rtl/base32_stream_encoder.sv
// ----------------------------------------------------------------------------
// base32_stream_encoder
// streaming base32 encoder (A-Z, 2-7 alphabet, '=' padding), bytes in, ascii out
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload                          per transaction
//   -------   ----------------   ------------------------------   ---------------
//   input     push / full        data_byte[7:0], final_byte       one byte
//   output    pop / empty        text_char[6:0], run_end,         one character
//                                message_end
//
// - a full group of five bytes, or a last partial group, gives eight characters
// - the back end emits one character per cycle while pop keeps up, so a group
//   of five bytes comes out as eight characters; the sustained rate is set by the
//   character sequencer in b32e_back
// - bytes are taken every cycle while the group queue has room; full follows
//   the queue alone
// - reset clears the byte gather, the queue and the output register; no
//   clearing pass, the block takes bytes from the first cycle after reset
// - a stalled output (pop low) holds the character in the output register and
//   backs up into the group queue, then the front
// ----------------------------------------------------------------------------
`default_nettype none

module base32_stream_encoder #(
    parameter int GROUP_QUEUE_DEPTH = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // byte input
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [b32e_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        final_byte,
    // character output
    output logic                             empty,
    input  wire logic                        pop,
    output logic [b32e_pkg::CHAR_W-1:0]      text_char,
    output logic                             run_end,
    output logic                             message_end
);
    import b32e_pkg::*;

    // front to queue
    logic   fq_push;
    group_t fq_data;
    logic   fq_full;
    // queue to back
    logic   qb_valid;
    group_t qb_data;
    logic   qb_pop;

    // gather bytes, classify group end (fifth byte or last byte)
    b32e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .grp_push   (fq_push),
        .grp_data   (fq_data),
        .grp_full   (fq_full)
    );

    // decouples byte intake from character output
    b32e_queue #(
        .DEPTH (GROUP_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fq_push),
        .wr_data  (fq_data),
        .full     (fq_full),
        .rd_en    (qb_pop),
        .rd_data  (qb_data),
        .nonempty (qb_valid)
    );

    // eight characters per group, next group loaded on the eighth
    b32e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_valid   (qb_valid),
        .grp_data    (qb_data),
        .grp_pop     (qb_pop),
        .empty       (empty),
        .pop         (pop),
        .text_char   (text_char),
        .run_end     (run_end),
        .message_end (message_end)
    );

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !fq_push)
        else $error("group pushed into full queue");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(text_char) && $stable(run_end))
        else $error("stalled character changed");

    a_msg_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && message_end |-> run_end)
        else $error("message end without run end");

endmodule

`default_nettype wire

>>> tb/base32_stream_encoder_tb.sv
// ----------------------------------------------------------------------------
// base32_stream_encoder_tb
// self-checking bench for the streaming base32 encoder: a directed table of
// byte transactions, then random messages, under random idling on both sides;
// every character popped is compared against a typed run or a cycle-free encoder model
// ----------------------------------------------------------------------------

module base32_stream_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b32e_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS  = 310;
    localparam int LONG_HOLD     = 250;   // receiver back-pressure stretch, cycles
    localparam int HOLD_AT_CHAR  = 100;   // character count that starts the stretch
    localparam int DRAIN_CYCLES  = 20;    // quiet cycles after the last character
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int REPORT_LIMIT  = 10;

    // alphabet anchors
    localparam logic [CHAR_W-1:0] ALPHA_FIRST = 7'd65;   // 'A'
    localparam logic [CHAR_W-1:0] DIGIT_FIRST = 7'd50;   // '2'
    localparam int                ALPHA_SIZE  = 26;

    // one character transaction as seen on the output ports
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              run_end;
        logic              msg_end;
    } text_item_t;

    // directed stimulus row; typed rows carry the eight characters of the run
    // they complete, every other row is checked against the encoder model
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              fin;
        logic              typed;
        logic [63:0]       run;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // single-byte messages straight after reset: both extremes
        '{8'h00, 1'b1, 1'b1, "AA======"},
        '{8'hFF, 1'b1, 1'b1, "74======"},
        // two-byte message
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b1, 1'b1, "777Q===="},
        // three-byte message
        '{8'h00, 1'b0, 1'b0, 64'd0},
        '{8'h00, 1'b0, 1'b0, 64'd0},
        '{8'h00, 1'b1, 1'b1, "AAAAA==="},
        // four-byte message, the longest partial group
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b1, 1'b1, "777777Y="},
        // full group that does not end the message: run_end without message_end
        '{8'h00, 1'b0, 1'b0, 64'd0},
        '{8'h00, 1'b0, 1'b0, 64'd0},
        '{8'h00, 1'b0, 1'b0, 64'd0},
        '{8'h00, 1'b0, 1'b0, 64'd0},
        '{8'h00, 1'b0, 1'b1, "AAAAAAAA"},
        // same message closed by a full group: no padding at all
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, 64'd0},
        '{8'hFF, 1'b1, 1'b1, "77777777"},
        // mid-alphabet letters
        '{8'h66, 1'b1, 1'b1, "MY======"},
        // alternating bit patterns, model checked
        '{8'h3C, 1'b0, 1'b0, 64'd0},
        '{8'hC3, 1'b1, 1'b0, 64'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              final_byte = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [CHAR_W-1:0] text_char;
    logic              run_end;
    logic              message_end;

    // encoder model state
    logic [31:0]       gather_bits = '0;
    logic [HELD_W-1:0] gather_count = '0;
    text_item_t        predicted_run[$];

    // characters still owed by the block, oldest first
    text_item_t        expected_text_q[$];

    int                error_count = 0;
    int                chars_checked = 0;
    logic              tx_burst = 1'b0;

    base32_stream_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .empty       (empty),
        .pop         (pop),
        .text_char   (text_char),
        .run_end     (run_end),
        .message_end (message_end)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d characters outstanding", expected_text_q.size());
        $display("base32_stream_encoder_tb NOT OK");
        $finish;
    end

    // counts every failure, prints only the first few
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // encoder model: absorbs one byte and leaves the run it completes,
    // if any, in predicted_run
    function automatic void encode_byte(input logic [BYTE_W-1:0] d, input logic fin);
        logic [39:0] bits;
        logic [4:0]  code;
        int          n;
        int          nchars;
        text_item_t  item;
        predicted_run.delete();
        // a count above four cannot happen; treat it as four
        n = (gather_count > 3'd4) ? 5 : int'(gather_count) + 1;
        bits = {gather_bits, d};
        if (n != 5 && !fin) begin
            gather_bits  = bits[31:0];
            gather_count = HELD_W'(n);
            return;
        end
        // zero-fill a partial group up to 40 bits, first byte on top
        bits   = bits << (8 * (5 - n));
        nchars = (8 * n + 4) / 5;
        for (int k = 0; k < CHARS_PER_RUN; k++) begin
            code = bits[39 - 5 * k -: 5];
            if (k >= nchars)
                item.ch = PAD_CHAR;
            else if (code < ALPHA_SIZE)
                item.ch = ALPHA_FIRST + CHAR_W'(code);
            else
                item.ch = DIGIT_FIRST + CHAR_W'(code - ALPHA_SIZE);
            item.run_end = (k == CHARS_PER_RUN - 1);
            item.msg_end = (k == CHARS_PER_RUN - 1) && fin;
            predicted_run.push_back(item);
        end
        gather_bits  = '0;
        gather_count = '0;
    endfunction

    // offers one byte transaction after an idle gap and returns at the edge
    // where it is taken; push stays high when the next gap is zero
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic fin, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= d;
        final_byte <= fin;
        @(posedge clk);
        while (full) @(posedge clk);
        encode_byte(d, fin);
    endtask

    // sender idle draw: zero inside a burst, else 0..15
    function automatic int tx_gap();
        return tx_burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    // hold the sender until the block has handed out every owed character
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_text_q.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, occasional no-stall stretches, and one long
    // hold-off so the group queue fills and full backs up into the sender
    // ------------------------------------------------------------------
    initial begin
        int         stall;
        int         burst_left;
        text_item_t got;
        text_item_t want;
        burst_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (chars_checked == HOLD_AT_CHAR)
                stall = LONG_HOLD;
            else if (burst_left > 0) begin
                stall = 0;
                burst_left--;
            end
            else if ($urandom_range(0, 7) == 0) begin
                stall = 0;
                burst_left = $urandom_range(16, 48);
            end
            else
                stall = $urandom_range(0, 15);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            // transaction taken at this edge; ports still hold its payload
            got = '{text_char, run_end, message_end};
            chars_checked++;
            if (expected_text_q.size() == 0)
                flag_error($sformatf("unexpected char 0x%02h run_end %0b message_end %0b",
                                     got.ch, got.run_end, got.msg_end));
            else begin
                want = expected_text_q.pop_front();
                if (got.ch !== want.ch || got.run_end !== want.run_end ||
                    got.msg_end !== want.msg_end)
                    flag_error($sformatf(
                        "char %0d: expected 0x%02h/%0b/%0b, got 0x%02h/%0b/%0b",
                        chars_checked, want.ch, want.run_end, want.msg_end,
                        got.ch, got.run_end, got.msg_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and end of run
    // ------------------------------------------------------------------
    initial begin
        dir_row_t          row;
        text_item_t        item;
        int                sent;
        int                msg_len;
        logic [BYTE_W-1:0] d;

        // reset held low from the start, released on a rising edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            tx_burst = (r >= 11 && r <= 20);    // the two full groups go back to back
            send_byte(row.data, row.fin, tx_gap());
            if (row.typed) begin
                for (int k = 0; k < CHARS_PER_RUN; k++) begin
                    item.ch      = CHAR_W'(row.run[63 - 8 * k -: 8]);
                    item.run_end = (k == CHARS_PER_RUN - 1);
                    item.msg_end = (k == CHARS_PER_RUN - 1) && row.fin;
                    expected_text_q.push_back(item);
                end
            end
            else
                foreach (predicted_run[i]) expected_text_q.push_back(predicted_run[i]);
        end

        // sender pause: let the block drain completely before random traffic
        wait_drained();

        // random messages: mostly short, a few long; bytes lean on the extremes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS / 2 && sent - msg_len < RANDOM_ITEMS / 2)
                wait_drained();
            msg_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < msg_len; i++) begin
                case ($urandom_range(0, 7))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = BYTE_W'($urandom);
                endcase
                send_byte(d, i == msg_len - 1, tx_gap());
                foreach (predicted_run[j]) expected_text_q.push_back(predicted_run[j]);
            end
            sent += msg_len;
        end
        push <= 1'b0;

        // drain, then a quiet window to catch stray characters
        while (expected_text_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_text_q.size() != 0)
            flag_error($sformatf("%0d characters never arrived", expected_text_q.size()));

        if (error_count == 0)
            $display("base32_stream_encoder_tb OK");
        else
            $display("base32_stream_encoder_tb NOT OK");
        $finish;
    end

endmodule
